// File: src/fpr_pkg.sv
// ----------------------------------------------------------------------------
// fpr_pkg
// Types and constants shared by the framed packet receiver.
// ----------------------------------------------------------------------------
package fpr_pkg;

  typedef enum logic [1:0] {
    PH_WAIT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_FOOTER  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_END   = 3'd1,
    ST_BAD_MODULE = 3'd2,
    ST_TOO_LONG  = 3'd3,
    ST_CHECKSUM  = 3'd4
  } status_t;

  localparam logic [1:0] REG_START_SYMBOL  = 2'd0;
  localparam logic [1:0] REG_END_SYMBOL    = 2'd1;
  localparam logic [1:0] REG_MAX_PAYLOAD   = 2'd2;
  localparam logic [1:0] REG_MAX_MODULE_ID = 2'd3;

  localparam int CNT_W      = 11;
  localparam int IDX_W      = 10;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 11;
  localparam int OUT_DATA_W = 56;

  localparam logic [CNT_W-1:0] HDR_MODULE  = 11'd1;
  localparam logic [CNT_W-1:0] HDR_COMMAND = 11'd2;
  localparam logic [CNT_W-1:0] HDR_LEN_HI  = 11'd3;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

endpackage

// File: src/framed_packet_receiver_core.sv
// ----------------------------------------------------------------------------
// framed_packet_receiver_core
// Byte-stream packet deframer with 16-bit two's-complement checksum check.
// ----------------------------------------------------------------------------
// Takes one byte per cycle with no bubbles: each accepted byte updates the
// frame state and, when it produces a result, loads the single output
// register in the same cycle. The input is stalled only while that output
// register holds a result the sink has not taken. Each payload byte yields a
// payload transaction (tuser 0); each frame yields one status transaction
// (tuser 1), either right after the header when the length is too large or
// after the end byte.
module framed_packet_receiver_core
  import fpr_pkg::*;
#(
  parameter int MAX_PAYLOAD_BYTES = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] payload_byte, [17:8] payload_index, [25:18] module_id,
  // [33:26] command, [49:34] length, [52:50] status, [55:53] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser,   // [0] kind
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [15:0] LIMIT_CAP = 16'(MAX_PAYLOAD_BYTES);

  logic [7:0]       start_symbol;
  logic [7:0]       end_symbol;
  logic [10:0]      max_payload;
  logic [7:0]       max_module_id;

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [15:0]      payload_length, payload_length_next;
  logic [15:0]      running_sum, running_sum_next;
  logic [7:0]       held_module, held_module_next;
  logic [7:0]       held_command, held_command_next;
  logic [7:0]       checksum_high, checksum_high_next;

  logic             emit;
  logic             emit_kind;
  logic [2:0]       emit_status;
  logic             in_fire;
  logic [7:0]       b;
  logic [15:0]      limit;
  logic [CNT_W-1:0] count_inc;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign count_inc     = byte_count + 1'b1;
  assign limit         = ({5'd0, max_payload} > LIMIT_CAP) ? LIMIT_CAP : {5'd0, max_payload};

  always_ff @(posedge clk) begin
    if (rst) begin
      start_symbol  <= 8'd1;
      end_symbol    <= 8'd4;
      max_payload   <= 11'd1024;
      max_module_id <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_W'(REG_START_SYMBOL):  start_symbol  <= cfg_data[7:0];
        CFG_IDX_W'(REG_END_SYMBOL):    end_symbol    <= cfg_data[7:0];
        CFG_IDX_W'(REG_MAX_PAYLOAD):   max_payload   <= cfg_data;
        CFG_IDX_W'(REG_MAX_MODULE_ID): max_module_id <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next          = phase;
    byte_count_next     = byte_count;
    payload_length_next = payload_length;
    running_sum_next    = running_sum;
    held_module_next    = held_module;
    held_command_next   = held_command;
    checksum_high_next  = checksum_high;
    emit                = 1'b0;
    emit_kind           = KIND_PAYLOAD;
    emit_status         = ST_OK;
    case (phase)
      PH_WAIT: begin
        if (b == start_symbol) begin
          running_sum_next = {8'd0, b};
          byte_count_next  = HDR_MODULE;
          phase_next       = PH_HEADER;
        end
      end
      PH_HEADER: begin
        running_sum_next = running_sum + {8'd0, b};
        byte_count_next  = count_inc;
        if (byte_count == HDR_MODULE) begin
          held_module_next = b;
        end else if (byte_count == HDR_COMMAND) begin
          held_command_next = b;
        end else if (byte_count == HDR_LEN_HI) begin
          payload_length_next = {b, 8'd0};
        end else begin
          payload_length_next = {payload_length[15:8], b};
          byte_count_next     = '0;
          if (payload_length_next > limit) begin
            phase_next  = PH_WAIT;
            emit        = 1'b1;
            emit_kind   = KIND_STATUS;
            emit_status = (held_module > max_module_id) ? ST_BAD_MODULE : ST_TOO_LONG;
          end else if (payload_length_next == 16'd0) begin
            phase_next = PH_FOOTER;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        running_sum_next = running_sum + {8'd0, b};
        emit             = 1'b1;
        byte_count_next  = count_inc;
        if ({5'd0, count_inc} >= payload_length) begin
          byte_count_next = '0;
          phase_next      = PH_FOOTER;
        end
      end
      PH_FOOTER: begin
        if (byte_count == '0) begin
          checksum_high_next = b;
          byte_count_next    = CNT_W'(1);
        end else if (byte_count == CNT_W'(1)) begin
          running_sum_next = running_sum + {checksum_high, b};
          byte_count_next  = CNT_W'(2);
        end else begin
          phase_next      = PH_WAIT;
          byte_count_next = '0;
          emit            = 1'b1;
          emit_kind       = KIND_STATUS;
          if (b != end_symbol) begin
            emit_status = ST_BAD_END;
          end else if (held_module > max_module_id) begin
            emit_status = ST_BAD_MODULE;
          end else if (running_sum != 16'd0) begin
            emit_status = ST_CHECKSUM;
          end else begin
            emit_status = ST_OK;
          end
        end
      end
      default: phase_next = PH_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_WAIT;
      byte_count     <= '0;
      payload_length <= '0;
      running_sum    <= '0;
      held_module    <= '0;
      held_command   <= '0;
      checksum_high  <= '0;
    end else if (in_fire) begin
      phase          <= phase_next;
      byte_count     <= byte_count_next;
      payload_length <= payload_length_next;
      running_sum    <= running_sum_next;
      held_module    <= held_module_next;
      held_command   <= held_command_next;
      checksum_high  <= checksum_high_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_axis_tvalid <= emit;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      m_axis_tuser <= emit_kind;
      m_axis_tdata <= {3'd0, emit_status, payload_length_next, held_command_next,
                       held_module_next,
                       (emit_kind == KIND_PAYLOAD) ? byte_count[IDX_W-1:0] : {IDX_W{1'b0}},
                       (emit_kind == KIND_PAYLOAD) ? b : 8'd0};
    end
  end

`ifndef SYNTH
  a_payload_status_ok: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_PAYLOAD) |-> (m_axis_tdata[52:50] == ST_OK))
    else $error("payload transaction carries nonzero status");

  a_wait_count_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_WAIT) |-> (byte_count == '0))
    else $error("byte count not cleared while hunting for start");

  a_payload_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> ({5'd0, byte_count} < payload_length))
    else $error("payload index beyond header length");

  a_payload_emits: assert property (@(posedge clk) disable iff (rst)
    (in_fire && phase == PH_PAYLOAD) |=> (m_axis_tvalid && m_axis_tuser == KIND_PAYLOAD))
    else $error("payload byte produced no result");
`endif

endmodule
